### hdl/numsym_pkg.sv
package numsym_pkg;

	localparam int WORLD_CELLS = 128;
	localparam int CELL_BITS   = 8;
	localparam int IDX_W       = $clog2(WORLD_CELLS);
	localparam int CNT_W       = IDX_W + 1;
	localparam int POS_W       = IDX_W + 3;
	localparam int SUM_W       = CELL_BITS + 2;

	typedef logic signed [CELL_BITS-1:0] cell_t;
	typedef logic signed [POS_W-1:0]     pos_t;
	typedef logic signed [SUM_W-1:0]     sum_t;
	typedef logic [IDX_W-1:0]            idx_t;
	typedef logic [CNT_W-1:0]            cnt_t;

	localparam cell_t XMARK   = {1'b1, {(CELL_BITS-1){1'b0}}};
	localparam cell_t SAT_MAX = {1'b0, {(CELL_BITS-1){1'b1}}};
	localparam cell_t SAT_MIN = -SAT_MAX;

	// request opcodes
	localparam logic [1:0] OP_LOAD = 2'd0;
	localparam logic [1:0] OP_STEP = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;

	// reproduction norms
	localparam logic [1:0] NORM_BASIC = 2'd0;
	localparam logic [1:0] NORM_SYMB  = 2'd1;
	localparam logic [1:0] NORM_EXCL  = 2'd2;
	localparam logic [1:0] NORM_COND  = 2'd3;

	// register index (paddr[2])
	localparam logic REG_NORM = 1'b0;
	localparam logic REG_SIZE = 1'b1;

	typedef struct packed {
		logic [1:0] norm_mode;
		logic [7:0] world_size;
	} cfg_t;

	typedef struct packed {
		logic  en;
		idx_t  addr;
		cell_t data;
	} ram_wr_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_FETCH,
		ST_DECIDE,
		ST_BA_RD,
		ST_BA_WR,
		ST_CH_TEST,
		ST_CH_RD,
		ST_NL_RD,
		ST_NL_CHK,
		ST_NR_RD,
		ST_NR_CHK,
		ST_COPY
	} state_t;

endpackage

### hdl/numsym_ram.sv
module numsym_ram
	import numsym_pkg::*;
(
	input  logic    clk,
	input  ram_wr_t wr,
	input  idx_t    raddr,
	output cell_t   rdata
);

	cell_t mem [WORLD_CELLS];

	// one write port
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// registered read, old data on a same-cycle write
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

### hdl/numsym_cfg.sv
module numsym_cfg
	import numsym_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	logic [1:0] norm_mode_q;
	logic [7:0] world_size_q;
	logic       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			norm_mode_q  <= NORM_BASIC;
			world_size_q <= 8'd10;
		end else if (wr_en) begin
			case (paddr[2])
				REG_NORM: norm_mode_q  <= pwdata[1:0];
				REG_SIZE: world_size_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// read-back
	always_comb begin
		case (paddr[2])
			REG_NORM: prdata = {30'd0, norm_mode_q};
			REG_SIZE: prdata = {24'd0, world_size_q};
			default:  prdata = '0;
		endcase
	end

	assign cfg = '{norm_mode: norm_mode_q, world_size: world_size_q};

endmodule

### hdl/numsym_seq.sv
module numsym_seq
	import numsym_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] op,
	input  idx_t       cell_index,
	input  cell_t      cell_value,
	output logic       out_valid,
	input  logic       out_ready,
	output cell_t      read_value,
	output ram_wr_t    cur_wr,
	output idx_t       cur_raddr,
	input  cell_t      cur_rd,
	output ram_wr_t    nxt_wr,
	output idx_t       nxt_raddr,
	input  cell_t      nxt_rd
);

	function automatic cell_t sat_sum(sum_t s);
		if (s > sum_t'(SAT_MAX)) return SAT_MAX;
		if (s < sum_t'(SAT_MIN)) return SAT_MIN;
		return cell_t'(s);
	endfunction

	function automatic cell_t sat_pos(pos_t s);
		if (s > pos_t'(SAT_MAX)) return SAT_MAX;
		if (s < pos_t'(SAT_MIN)) return SAT_MIN;
		return cell_t'(s);
	endfunction

	function automatic logic is_num(cell_t c);
		return (c != '0) && (c != XMARK);
	endfunction

	function automatic pos_t to_pos(cnt_t c);
		return $signed({{(POS_W-CNT_W){1'b0}}, c});
	endfunction

	// collision rule of the basic norm
	function automatic cell_t basic_add(cell_t nv, cell_t cv, cell_t v);
		sum_t below;
		below = ((cv == XMARK) || (nv == '0)) ? sum_t'(0) : sum_t'(cv);
		return sat_sum(sum_t'(nv) + sum_t'(v) - below);
	endfunction

	state_t state_q, state_d;
	cnt_t   i_q, i_d, n_q, n_d, k_q, k_d, lvl_q, lvl_d;
	pos_t   j_q, j_d, p_q, p_d, lp_q, lp_d;
	cell_t  v_q, v_d, w_q, w_d, ln_q, ln_d;
	logic   out_valid_q, out_valid_d;
	cell_t  out_data_q, out_data_d;

	pos_t   i_pos, n_pos, c_pos, jw_pos;
	cell_t  w_sel, gap;
	cnt_t   km1;
	logic   do_cont, brk, cond;

	assign i_pos = to_pos(i_q);
	assign n_pos = to_pos(n_q);
	assign cond  = (cfg.norm_mode == NORM_COND);
	assign km1   = k_q - cnt_t'(1);
	assign c_pos = i_pos + pos_t'(cur_rd);
	assign gap   = sat_pos(p_q - lp_q);

	// chain continuation, shared by the placement states
	assign w_sel  = (state_q == ST_CH_RD) ? cur_rd : w_q;
	assign jw_pos = i_pos + pos_t'(w_sel);
	assign brk    = !is_num(w_sel) || (w_sel == v_q) || (cond && (jw_pos == j_q));

	// next state and datapath
	always_comb begin
		state_d     = state_q;
		i_d         = i_q;
		n_d         = n_q;
		k_d         = k_q;
		lvl_d       = lvl_q;
		j_d         = j_q;
		p_d         = p_q;
		lp_d        = lp_q;
		v_d         = v_q;
		w_d         = w_q;
		ln_d        = ln_q;
		out_valid_d = out_valid_q && !out_ready;
		out_data_d  = out_data_q;
		in_ready    = 1'b0;
		cur_wr      = '0;
		nxt_wr      = '0;
		cur_raddr   = i_q[IDX_W-1:0];
		nxt_raddr   = i_q[IDX_W-1:0];
		do_cont     = 1'b0;

		case (state_q)
			ST_CLEAR: begin
				cur_wr = '{en: 1'b1, addr: k_q[IDX_W-1:0], data: '0};
				nxt_wr = '{en: 1'b1, addr: k_q[IDX_W-1:0], data: '0};
				if (k_q == cnt_t'(WORLD_CELLS - 1)) begin
					state_d = ST_IDLE;
				end else begin
					k_d = k_q + cnt_t'(1);
				end
			end
			ST_IDLE: begin
				in_ready = !out_valid_q || out_ready;
				if (in_valid && in_ready) begin
					case (op)
						OP_LOAD: begin
							cur_wr      = '{en: 1'b1, addr: cell_index, data: cell_value};
							out_valid_d = 1'b1;
							out_data_d  = '0;
						end
						OP_READ: begin
							cur_raddr = cell_index;
							state_d   = ST_READ;
						end
						OP_STEP: begin
							n_d     = (cfg.world_size > 8'(WORLD_CELLS)) ?
								cnt_t'(WORLD_CELLS) : cnt_t'(cfg.world_size);
							i_d     = '0;
							state_d = ST_FETCH;
						end
						default: begin
							out_valid_d = 1'b1;
							out_data_d  = '0;
						end
					endcase
				end
			end
			ST_READ: begin
				out_valid_d = 1'b1;
				out_data_d  = cur_rd;
				state_d     = ST_IDLE;
			end
			ST_FETCH: begin
				if (i_q >= n_q) begin
					k_d     = '0;
					state_d = ST_COPY;
				end else begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				v_d = cur_rd;
				if (cfg.norm_mode == NORM_BASIC) begin
					if (cur_rd == XMARK) begin
						if (nxt_rd == '0) begin
							nxt_wr = '{en: 1'b1, addr: i_q[IDX_W-1:0], data: XMARK};
						end
						i_d     = i_q + cnt_t'(1);
						state_d = ST_FETCH;
					end else begin
						if (nxt_rd != XMARK) begin
							nxt_wr = '{en: 1'b1, addr: i_q[IDX_W-1:0],
								data: basic_add(nxt_rd, cur_rd, cur_rd)};
						end
						if ((cur_rd != '0) && (c_pos >= 0) && (c_pos < n_pos)) begin
							j_d     = c_pos;
							state_d = ST_BA_RD;
						end else begin
							i_d     = i_q + cnt_t'(1);
							state_d = ST_FETCH;
						end
					end
				end else if (!is_num(cur_rd)) begin
					i_d     = i_q + cnt_t'(1);
					state_d = ST_FETCH;
				end else begin
					j_d     = c_pos;
					lvl_d   = cnt_t'(1);
					state_d = ST_CH_TEST;
				end
			end
			ST_BA_RD: begin
				cur_raddr = j_q[IDX_W-1:0];
				nxt_raddr = j_q[IDX_W-1:0];
				state_d   = ST_BA_WR;
			end
			ST_BA_WR: begin
				if (nxt_rd != XMARK) begin
					nxt_wr = '{en: 1'b1, addr: j_q[IDX_W-1:0],
						data: basic_add(nxt_rd, cur_rd, v_q)};
				end
				i_d     = i_q + cnt_t'(1);
				state_d = ST_FETCH;
			end
			ST_CH_TEST: begin
				if ((lvl_q <= n_q) && (j_q >= 0) && (j_q < n_pos)) begin
					cur_raddr = j_q[IDX_W-1:0];
					nxt_raddr = j_q[IDX_W-1:0];
					state_d   = ST_CH_RD;
				end else begin
					i_d     = i_q + cnt_t'(1);
					state_d = ST_FETCH;
				end
			end
			ST_CH_RD: begin
				w_d = cur_rd;
				if (cfg.norm_mode == NORM_SYMB || nxt_rd == '0) begin
					nxt_wr  = '{en: 1'b1, addr: j_q[IDX_W-1:0], data: v_q};
					do_cont = 1'b1;
				end else if (nxt_rd == v_q) begin
					do_cont = 1'b1;
				end else if (!cond || is_num(cur_rd)) begin
					nxt_wr  = '{en: 1'b1, addr: j_q[IDX_W-1:0], data: XMARK};
					do_cont = 1'b1;
				end else begin
					// conflict on a cell that holds no number: look for the nearest numbers either side
					p_d     = j_q - pos_t'(1);
					state_d = ST_NL_RD;
				end
			end
			ST_NL_RD: begin
				if (p_q < 0) begin
					nxt_wr  = '{en: 1'b1, addr: j_q[IDX_W-1:0], data: XMARK};
					do_cont = 1'b1;
				end else begin
					cur_raddr = p_q[IDX_W-1:0];
					state_d   = ST_NL_CHK;
				end
			end
			ST_NL_CHK: begin
				if (is_num(cur_rd)) begin
					lp_d    = p_q;
					ln_d    = cur_rd;
					p_d     = j_q + pos_t'(1);
					state_d = ST_NR_RD;
				end else begin
					p_d     = p_q - pos_t'(1);
					state_d = ST_NL_RD;
				end
			end
			ST_NR_RD: begin
				if (p_q >= n_pos) begin
					nxt_wr  = '{en: 1'b1, addr: j_q[IDX_W-1:0], data: XMARK};
					do_cont = 1'b1;
				end else begin
					cur_raddr = p_q[IDX_W-1:0];
					state_d   = ST_NR_CHK;
				end
			end
			ST_NR_CHK: begin
				if (is_num(cur_rd)) begin
					nxt_wr  = '{en: 1'b1, addr: j_q[IDX_W-1:0],
						data: ((ln_q > 0) == (cur_rd > 0)) ? gap : -gap};
					do_cont = 1'b1;
				end else begin
					p_d     = p_q + pos_t'(1);
					state_d = ST_NR_RD;
				end
			end
			ST_COPY: begin
				// read entry k, move entry k-1 and blank it
				if (k_q < cnt_t'(WORLD_CELLS)) begin
					nxt_raddr = k_q[IDX_W-1:0];
				end
				if (k_q != '0) begin
					cur_wr = '{en: 1'b1, addr: km1[IDX_W-1:0], data: nxt_rd};
					nxt_wr = '{en: 1'b1, addr: km1[IDX_W-1:0], data: '0};
				end
				if (k_q == cnt_t'(WORLD_CELLS)) begin
					out_valid_d = 1'b1;
					out_data_d  = '0;
					state_d     = ST_IDLE;
				end else begin
					k_d = k_q + cnt_t'(1);
				end
			end
			default: state_d = ST_IDLE;
		endcase

		if (do_cont) begin
			if (brk) begin
				i_d     = i_q + cnt_t'(1);
				state_d = ST_FETCH;
			end else begin
				j_d     = jw_pos;
				lvl_d   = lvl_q + cnt_t'(1);
				state_d = ST_CH_TEST;
			end
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			k_q         <= k_d;
			out_valid_q <= out_valid_d;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		i_q        <= i_d;
		n_q        <= n_d;
		lvl_q      <= lvl_d;
		j_q        <= j_d;
		p_q        <= p_d;
		lp_q       <= lp_d;
		v_q        <= v_d;
		w_q        <= w_d;
		ln_q       <= ln_d;
		out_data_q <= out_data_d;
	end

	assign out_valid  = out_valid_q;
	assign read_value = out_data_q;

endmodule

### hdl/numeric_symbioorganism_generation.sv
// One-dimensional world of numeric organisms held in two cell memories.
// Request channel (in_valid/in_ready): op, cell_index, cell_value.
//   load writes a cell, read returns a cell, advance runs one generation
//   under the norm held in the norm_mode register.
// Result channel (out_valid/out_ready): one read_value per request, zero
//   for everything but a read.
// Registers over the APB port: 0 norm_mode, 4 world_size; no wait states.
// Sequencing: a load registers a zero result; a read also passes the
//   registered memory read. An advance walks the world's cells through
//   the single read port of each memory: fetch and decide per cell, read
//   and write of the offset cell in the basic norm, test and read per chain
//   step, read and check per cell scanned in a nearest-number search, then
//   a pass that moves the next buffer into the current one.
// While a reset pass blanks both memories, only register writes are taken.
// A stalled result stays in the output register; a new request is taken
//   in the cycle that register empties.
module numeric_symbioorganism_generation
	import numsym_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        op,
	input  logic [6:0]        cell_index,
	input  logic signed [7:0] cell_value,
	output logic              out_valid,
	input  logic              out_ready,
	output logic signed [7:0] read_value
);

	cfg_t    cfg;
	ram_wr_t cur_wr, nxt_wr;
	idx_t    cur_raddr, nxt_raddr;
	cell_t   cur_rd, nxt_rd;

	numsym_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// current generation
	numsym_ram u_cur (
		.clk   (clk),
		.wr    (cur_wr),
		.raddr (cur_raddr),
		.rdata (cur_rd)
	);

	// generation under construction
	numsym_ram u_nxt (
		.clk   (clk),
		.wr    (nxt_wr),
		.raddr (nxt_raddr),
		.rdata (nxt_rd)
	);

	numsym_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.cell_index (cell_index),
		.cell_value (cell_value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.read_value (read_value),
		.cur_wr     (cur_wr),
		.cur_raddr  (cur_raddr),
		.cur_rd     (cur_rd),
		.nxt_wr     (nxt_wr),
		.nxt_raddr  (nxt_raddr),
		.nxt_rd     (nxt_rd)
	);

endmodule

### hdl/numsym_chk.sv
module numsym_chk
	import numsym_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic [1:0]        op,
	input logic              out_valid,
	input logic              out_ready,
	input logic signed [7:0] read_value
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(read_value))
		else $error("result changed while stalled");

	// a load answers zero in the next cycle
	a_load_zero: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (op == OP_LOAD) |=> out_valid && (read_value == '0))
		else $error("load result missing or non-zero");

	// a read keeps the request side closed for its memory cycle
	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (op == OP_READ) |=> !in_ready)
		else $error("request taken during a read");

	// an advance gives no result and takes no request in the next cycle
	a_step_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (op == OP_STEP) |=> !out_valid && !in_ready)
		else $error("advance finished too early");

endmodule

bind numeric_symbioorganism_generation numsym_chk u_chk (.*);

### tb/tb.sv
module tb;
	import numsym_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// a conditional-norm advance over a full world can run long before its result
	localparam int WATCHDOG_LIMIT = 20000000;
	localparam int DRAIN_CYCLES   = 2000;

	// world predictor and expected read values
	class world_scoreboard;
		int cur_cells[WORLD_CELLS];
		int nxt_cells[WORLD_CELLS];
		logic [1:0] norm;
		int size;
		logic signed [7:0] read_q[$];
		int fails;

		function new();
			foreach (cur_cells[k]) begin
				cur_cells[k] = 0;
				nxt_cells[k] = 0;
			end
			norm = NORM_BASIC;
			size = 10;
			fails = 0;
		endfunction

		function int clip(int v);
			if (v > 127) return 127;
			if (v < -127) return -127;
			return v;
		endfunction

		function bit is_num(int v);
			return v != 0 && v != -128;
		endfunction

		function void basic_add(int c, int v);
			int below;
			if (nxt_cells[c] == -128) return;
			below = (cur_cells[c] == -128) ? 0 : cur_cells[c];
			if (nxt_cells[c] == 0) below = 0;
			nxt_cells[c] = clip(nxt_cells[c] + v - below);
		endfunction

		function int nearest(int j, int stp, int n, output int num);
			int p;
			p = j + stp;
			num = 0;
			while (p >= 0 && p < n) begin
				if (is_num(cur_cells[p])) begin
					num = cur_cells[p];
					return p;
				end
				p += stp;
			end
			return -1;
		endfunction

		function void settle(int i, int j, int n, bit cond);
			int v, ln, rn, lp, rp, d;
			v = cur_cells[i];
			if (nxt_cells[j] == 0) nxt_cells[j] = v;
			else if (nxt_cells[j] != v) begin
				if (!cond || is_num(cur_cells[j])) nxt_cells[j] = -128;
				else begin
					lp = nearest(j, -1, n, ln);
					rp = nearest(j, 1, n, rn);
					if (lp < 0 || rp < 0) nxt_cells[j] = -128;
					else begin
						d = clip(rp - lp);
						nxt_cells[j] = ((ln > 0) == (rn > 0)) ? d : -d;
					end
				end
			end
		endfunction

		function void grow_chain(int i, int n);
			int v, j, lvl, w;
			v = cur_cells[i];
			j = i + v;
			lvl = 1;
			while (lvl <= n && j >= 0 && j < n) begin
				w = cur_cells[j];
				if (norm == NORM_SYMB) nxt_cells[j] = v;
				else settle(i, j, n, norm == NORM_COND);
				if (!is_num(w) || w == v) break;
				if (norm == NORM_COND && i + w == j) break;
				j = i + w;
				lvl++;
			end
		endfunction

		function void advance();
			int n, v, c;
			n = (size > WORLD_CELLS) ? WORLD_CELLS : size;
			for (int i = 0; i < n; i++) begin
				if (norm == NORM_BASIC) begin
					v = cur_cells[i];
					if (v == -128) begin
						if (nxt_cells[i] == 0) nxt_cells[i] = -128;
					end else begin
						basic_add(i, v);
						c = i + v;
						if (v != 0 && c >= 0 && c < n) basic_add(c, v);
					end
				end else if (is_num(cur_cells[i])) grow_chain(i, n);
			end
			foreach (cur_cells[k]) begin
				cur_cells[k] = nxt_cells[k];
				nxt_cells[k] = 0;
			end
		endfunction

		function void note_request(logic [1:0] o, logic [6:0] idx, logic signed [7:0] val);
			logic signed [7:0] r;
			r = '0;
			if (o == OP_LOAD) cur_cells[idx] = (val == -128) ? -128 : clip(val);
			else if (o == OP_STEP) advance();
			else if (o == OP_READ) r = 8'(cur_cells[idx]);
			read_q.push_back(r);
		endfunction

		function void check_result(logic signed [7:0] got);
			logic signed [7:0] want;
			if (read_q.size() == 0) begin
				$error("read_value: none expected, got %0d", got);
				fails++;
				return;
			end
			want = read_q.pop_front();
			if (got !== want) begin
				$error("read_value: expected %0d, got %0d", want, got);
				fails++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] op = OP_LOAD;
	logic [6:0] cell_index = '0;
	logic signed [7:0] cell_value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [7:0] read_value;

	world_scoreboard sb = new();
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int quiet_cycles = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	numeric_symbioorganism_generation i_dut (.*);

	// result side: random stalls, check on acceptance
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) sb.check_result(read_value);
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// watchdog on cycles without any accepted request or result
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("numeric_symbioorganism_generation regression: fail");
			$finish;
		end
	end

	task automatic reg_write(logic reg_sel, int value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_sel, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (reg_sel == REG_NORM) sb.norm = value[1:0];
		else sb.size = value[7:0];
	endtask

	// valid drops only for idle cycles, so back-to-back requests keep it high
	task automatic send_request(logic [1:0] o, int idx, int val);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		cell_index <= idx[6:0];
		cell_value <= val[7:0];
		do @(posedge clk); while (!in_ready);
		sb.note_request(o, idx[6:0], val[7:0]);
	endtask

	task automatic settle_idle();
		in_valid <= 1'b0;
		while (sb.read_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// one random phase: seed cells, advance generations, read back, send the unused opcode
	task automatic run_phase(int reqs);
		int n, r;
		n = (sb.size > WORLD_CELLS || sb.size == 0) ? WORLD_CELLS : sb.size;
		for (int k = 0; k < reqs; k++) begin
			r = $urandom_range(99);
			if (r < 45) begin
				r = $urandom_range(9);
				send_request(OP_LOAD, (r == 0) ? $urandom_range(127) : $urandom_range(n - 1),
					(r < 2) ? $urandom_range(255) : (r < 3 ? -128 : $urandom_range(7) - 3));
			end else if (r < 55) send_request(OP_STEP, $urandom_range(127), $urandom_range(255));
			else if (r < 97) send_request(OP_READ, $urandom_range(127), $urandom_range(255));
			else send_request(2'd3, $urandom_range(127), $urandom_range(255));
		end
	endtask

	initial begin
		int sizes[6] = '{10, 1, 128, 0, 200, 24};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, X mark, every op, out-of-world cells
		send_request(OP_LOAD, 0, 127);
		send_request(OP_LOAD, 1, -127);
		send_request(OP_LOAD, 2, -128);
		send_request(OP_LOAD, 3, 2);
		send_request(OP_LOAD, 5, -1);
		send_request(OP_LOAD, 127, 85);
		send_request(OP_LOAD, 12, -86);
		send_request(OP_READ, 0, 0);
		send_request(OP_READ, 1, 0);
		send_request(OP_READ, 2, 0);
		send_request(OP_READ, 127, 0);
		send_request(2'd3, 127, -1);
		send_request(OP_STEP, 0, 0);
		for (int k = 0; k < 13; k += 1) send_request(OP_READ, k, 0);
		settle_idle();

		// random phases over every norm and several world sizes
		for (int p = 0; p < 24; p++) begin
			reg_write(REG_NORM, p % 4);
			reg_write(REG_SIZE, sizes[(p / 4) % 6]);
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
				default: begin send_idle_pct = 19; recv_stall_pct = 19; end
			endcase
			run_phase(80);
			settle_idle();
		end

		if (sb.fails == 0 && sb.read_q.size() == 0)
			$display("numeric_symbioorganism_generation regression: pass");
		else
			$display("numeric_symbioorganism_generation regression: fail");
		$finish;
	end

endmodule

### sim.f
hdl/numsym_pkg.sv
hdl/numsym_ram.sv
hdl/numsym_cfg.sv
hdl/numsym_seq.sv
hdl/numeric_symbioorganism_generation.sv
hdl/numsym_chk.sv
tb/tb.sv
